FILE: src/kat_pkg.sv
package kat_pkg;

	typedef enum logic [2:0] {
		FN_PUT       = 3'd0,
		FN_GET_VALUE = 3'd1,
		FN_GET_STAMP = 3'd2,
		FN_TOUCH     = 3'd3,
		FN_IDLE      = 3'd4,
		FN_REMOVE    = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL      = 2'd2
	} status_t;

	// update strobes broadcast to every cell, valid only in the commit cycle
	typedef struct packed {
		logic put_hit;
		logic touch;
		logic remove;
		logic append;
	} kat_ctl_t;

endpackage

FILE: src/kat_cell.sv
module kat_cell import kat_pkg::*; #(
	parameter int INDEX     = 0,
	parameter int CNT_W     = 5,
	parameter int KEY_BITS  = 64,
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  kat_ctl_t             ctl,
	input  logic [CNT_W-1:0]     count,
	input  logic [KEY_BITS-1:0]  req_key,
	input  logic [31:0]          req_value,
	input  logic [TIME_BITS-1:0] req_stamp,
	input  logic [KEY_BITS-1:0]  next_key,
	input  logic [31:0]          next_value,
	input  logic [TIME_BITS-1:0] next_stamp,
	input  logic                 seen_in,
	input  logic [31:0]          value_in,
	input  logic [TIME_BITS-1:0] stamp_in,
	output logic                 seen_out,
	output logic [31:0]          value_out,
	output logic [TIME_BITS-1:0] stamp_out,
	output logic                 hit,
	output logic [KEY_BITS-1:0]  key,
	output logic [31:0]          value,
	output logic [TIME_BITS-1:0] stamp
);

	logic [KEY_BITS-1:0]  key_q;
	logic [31:0]          value_q;
	logic [TIME_BITS-1:0] stamp_q;
	logic                 active;

	assign active    = CNT_W'(INDEX) < count;
	assign hit       = active && (key_q == req_key);
	assign seen_out  = seen_in | hit;
	assign value_out = value_in | (hit ? value_q : 32'd0);
	assign stamp_out = stamp_in | (hit ? stamp_q : {TIME_BITS{1'b0}});
	assign key       = key_q;
	assign value     = value_q;
	assign stamp     = stamp_q;

	always_ff @(posedge clk) begin
		if (ctl.remove && seen_out) begin
			key_q   <= next_key;
			value_q <= next_value;
			stamp_q <= next_stamp;
		end else if (ctl.append && (count == CNT_W'(INDEX))) begin
			key_q   <= req_key;
			value_q <= req_value;
			stamp_q <= req_stamp;
		end else if (ctl.put_hit && hit) begin
			value_q <= req_value;
			stamp_q <= req_stamp;
		end else if (ctl.touch && hit) begin
			stamp_q <= req_stamp;
		end
	end

endmodule

FILE: src/keyed_activity_table.sv
// Fully associative key/value table of CAPACITY entries, each with a
// last-active stamp, built as a row of cells that all compare the request
// key at once and pass the hit and its data along the row. A request is
// registered on acceptance, then looked up and committed once the output
// register can take its result (a held result stalls it there), and a new
// request is taken every cycle while results are drained.
// Remove shifts every later cell down by one in the same commit cycle.
module keyed_activity_table import kat_pkg::*; #(
	parameter int CAPACITY  = 16,
	parameter int KEY_BITS  = 64,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [63:0] lookup_key,
	input  logic [31:0] put_value,
	input  logic [31:0] now_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] result_data
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                 s1_valid_q;
	logic [2:0]           func_s1;
	logic [KEY_BITS-1:0]  key_s1;
	logic [31:0]          value_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [CNT_W-1:0]     count_q;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [31:0]          data_q;

	logic                 advance;
	logic                 found;
	logic                 room;
	kat_ctl_t             ctl;
	logic [1:0]           status_d;
	logic [31:0]          data_d;
	logic [TIME_BITS+31:0] now_wide;
	logic [TIME_BITS+31:0] stamp_wide;
	logic [TIME_BITS+31:0] idle_wide;
	logic [TIME_BITS-1:0] idle_time;

	logic                 seen_c  [CAPACITY+1];
	logic [31:0]          value_c [CAPACITY+1];
	logic [TIME_BITS-1:0] stamp_c [CAPACITY+1];
	logic [KEY_BITS-1:0]  key_w   [CAPACITY];
	logic [31:0]          value_w [CAPACITY];
	logic [TIME_BITS-1:0] stamp_w [CAPACITY];
	logic [CAPACITY-1:0]  hit_w;

	assign advance  = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !advance;
	assign now_wide = {{TIME_BITS{1'b0}}, now_time};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1  <= func;
			key_s1   <= lookup_key[KEY_BITS-1:0];
			value_s1 <= put_value;
			now_s1   <= now_wide[TIME_BITS-1:0];
		end
	end

	assign seen_c[0]  = 1'b0;
	assign value_c[0] = 32'd0;
	assign stamp_c[0] = {TIME_BITS{1'b0}};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int NXT = (i + 1 < CAPACITY) ? i + 1 : i;
		kat_cell #(
			.INDEX     (i),
			.CNT_W     (CNT_W),
			.KEY_BITS  (KEY_BITS),
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.req_key    (key_s1),
			.req_value  (value_s1),
			.req_stamp  (now_s1),
			.next_key   (key_w[NXT]),
			.next_value (value_w[NXT]),
			.next_stamp (stamp_w[NXT]),
			.seen_in    (seen_c[i]),
			.value_in   (value_c[i]),
			.stamp_in   (stamp_c[i]),
			.seen_out   (seen_c[i+1]),
			.value_out  (value_c[i+1]),
			.stamp_out  (stamp_c[i+1]),
			.hit        (hit_w[i]),
			.key        (key_w[i]),
			.value      (value_w[i]),
			.stamp      (stamp_w[i])
		);
	end

	assign found      = seen_c[CAPACITY];
	assign room       = count_q < CNT_W'(CAPACITY);
	assign idle_time  = now_s1 - stamp_c[CAPACITY];
	assign stamp_wide = {32'd0, stamp_c[CAPACITY]};
	assign idle_wide  = {32'd0, idle_time};

	always_comb begin
		ctl      = '0;
		status_d = STS_OK;
		data_d   = 32'd0;
		case (func_s1)
			FN_PUT: begin
				if (found) begin
					ctl.put_hit = advance;
				end else if (room) begin
					ctl.append = advance;
				end else begin
					status_d = STS_FULL;
				end
			end
			FN_GET_VALUE: begin
				if (found) begin
					data_d = value_c[CAPACITY];
				end else begin
					status_d = STS_NOT_FOUND;
				end
			end
			FN_GET_STAMP: begin
				if (found) begin
					data_d = stamp_wide[31:0];
				end else begin
					status_d = STS_NOT_FOUND;
				end
			end
			FN_TOUCH: begin
				if (found) begin
					ctl.touch = advance;
				end else begin
					status_d = STS_NOT_FOUND;
				end
			end
			FN_IDLE: begin
				if (found) begin
					data_d = idle_wide[31:0];
				end else begin
					status_d = STS_NOT_FOUND;
				end
			end
			FN_REMOVE: begin
				if (found) begin
					ctl.remove = advance;
				end else begin
					status_d = STS_NOT_FOUND;
				end
			end
			default: begin
				status_d = STS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.append) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.remove) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			data_q   <= data_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_data = data_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_w))
		else $error("more than one cell matched the key");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.append |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("append did not grow the table");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.remove |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("remove did not shrink the table");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

endmodule

FILE: test/tb_keyed_activity_table.sv
module tb_keyed_activity_table;
	import kat_pkg::*;

	localparam int CAPACITY = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [2:0] FN_SPARE_A = 3'd6;
	localparam logic [2:0] FN_SPARE_B = 3'd7;
	localparam logic [63:0] KEY_ZERO = 64'h0;
	localparam logic [63:0] KEY_ONES = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0] KEY_TOP = 64'h8000_0000_0000_0000;
	localparam logic [63:0] KEY_MISSING = 64'h7fff_ffff_ffff_ffff;

	typedef struct packed {
		status_t     sts;
		logic [31:0] data;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  func;
	logic [63:0] lookup_key;
	logic [31:0] put_value;
	logic [31:0] now_time;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] result_data;

	logic [63:0] known_keys[CAPACITY];
	logic [31:0] known_values[CAPACITY];
	logic [31:0] known_stamps[CAPACITY];
	int          known_count;
	outcome_t    pending_outcomes[$];
	int          mismatch_count;
	int          cycle_count;
	int          hold_cycles;
	bit          no_gaps;
	logic [31:0] wall_clock;

	keyed_activity_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.lookup_key(lookup_key),
		.put_value(put_value),
		.now_time(now_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.result_data(result_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// table predictor: applies one request and queues its outcome
	task automatic predict_request(input logic [2:0] f, input logic [63:0] key,
			input logic [31:0] value, input logic [31:0] now);
		int hit;
		outcome_t res;
		hit = -1;
		res.sts = STS_OK;
		res.data = '0;
		for (int i = 0; i < known_count; i++)
			if (hit < 0 && known_keys[i] == key)
				hit = i;
		case (f)
			FN_PUT: begin
				if (hit >= 0) begin
					known_values[hit] = value;
					known_stamps[hit] = now;
				end else if (known_count >= CAPACITY) begin
					res.sts = STS_FULL;
				end else begin
					known_keys[known_count] = key;
					known_values[known_count] = value;
					known_stamps[known_count] = now;
					known_count++;
				end
			end
			FN_GET_VALUE: begin
				if (hit >= 0)
					res.data = known_values[hit];
				else
					res.sts = STS_NOT_FOUND;
			end
			FN_GET_STAMP: begin
				if (hit >= 0)
					res.data = known_stamps[hit];
				else
					res.sts = STS_NOT_FOUND;
			end
			FN_TOUCH: begin
				if (hit >= 0)
					known_stamps[hit] = now;
				else
					res.sts = STS_NOT_FOUND;
			end
			FN_IDLE: begin
				if (hit >= 0)
					res.data = now - known_stamps[hit];
				else
					res.sts = STS_NOT_FOUND;
			end
			FN_REMOVE: begin
				if (hit >= 0) begin
					for (int j = hit; j + 1 < known_count; j++) begin
						known_keys[j] = known_keys[j + 1];
						known_values[j] = known_values[j + 1];
						known_stamps[j] = known_stamps[j + 1];
					end
					known_count--;
				end else begin
					res.sts = STS_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
		pending_outcomes.push_back(res);
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(input logic [2:0] f, input logic [63:0] key,
			input logic [31:0] value, input logic [31:0] now);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		lookup_key <= key;
		put_value <= value;
		now_time <= now;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_request(f, key, value, now);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_outcomes.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed_ops();
		send_request(FN_GET_VALUE, KEY_ZERO, 32'h1234_5678, 32'h0);
		send_request(FN_PUT, KEY_ZERO, 32'h0, 32'h0);
		send_request(FN_PUT, KEY_ONES, 32'hffff_ffff, 32'hffff_ffff);
		send_request(FN_PUT, KEY_TOP, 32'h5a5a_a5a5, 32'h0000_1000);
		send_request(FN_GET_VALUE, KEY_ONES, 32'hffff_ffff, 32'h0);
		send_request(FN_GET_STAMP, KEY_ZERO, 32'hffff_ffff, 32'hffff_ffff);
		send_request(FN_IDLE, KEY_ZERO, 32'h0, 32'hffff_ffff);
		send_request(FN_IDLE, KEY_ONES, 32'h0, 32'h0);
		send_request(FN_TOUCH, KEY_TOP, 32'hffff_ffff, 32'h0000_2000);
		send_request(FN_GET_STAMP, KEY_TOP, 32'h0, 32'h0);
		send_request(FN_TOUCH, KEY_MISSING, 32'h0, 32'h0000_3000);
		send_request(FN_PUT, KEY_ZERO, 32'hdead_beef, 32'h0000_0003);
		send_request(FN_GET_VALUE, KEY_ZERO, 32'h0, 32'h0);
		send_request(FN_SPARE_A, KEY_ONES, 32'hffff_ffff, 32'hffff_ffff);
		send_request(FN_SPARE_B, KEY_ZERO, 32'hffff_ffff, 32'hffff_ffff);
		send_request(FN_REMOVE, KEY_ZERO, 32'hffff_ffff, 32'h0);
		send_request(FN_GET_VALUE, KEY_TOP, 32'h0, 32'h0);
		send_request(FN_REMOVE, KEY_ZERO, 32'h0, 32'h0);
		send_request(FN_GET_STAMP, KEY_ZERO, 32'h0, 32'h0);
		send_request(FN_IDLE, KEY_MISSING, 32'h0, 32'hffff_ffff);
		send_request(FN_REMOVE, KEY_ONES, 32'h0, 32'h0);
		send_request(FN_REMOVE, KEY_TOP, 32'h0, 32'h0);
		send_request(FN_GET_VALUE, KEY_TOP, 32'h0, 32'h0);
		wait_for_results();
	endtask

	task automatic test_full_table();
		logic [63:0] base;
		base = {$urandom, $urandom};
		for (int i = 0; i < CAPACITY; i++)
			send_request(FN_PUT, base + 64'(i), $urandom, 32'(i));
		send_request(FN_PUT, base + 64'(CAPACITY), $urandom, 32'h100);
		send_request(FN_PUT, base + 64'(3), $urandom, 32'h101);
		send_request(FN_REMOVE, base + 64'(5), 32'h0, 32'h0);
		send_request(FN_GET_VALUE, base + 64'(6), 32'h0, 32'h0);
		send_request(FN_PUT, base + 64'(CAPACITY), $urandom, 32'h102);
		send_request(FN_IDLE, base + 64'(CAPACITY - 1), 32'h0, 32'h200);
		for (int i = CAPACITY; i >= 0; i--)
			send_request(FN_REMOVE, base + 64'(i), 32'h0, 32'h0);
		wait_for_results();
	endtask

	task automatic test_random_mix(input int n_items, input int pool_size,
			input int put_weight, input int remove_weight);
		logic [63:0] pool[48];
		logic [2:0]  lookup_codes[4];
		logic [2:0]  f;
		logic [63:0] key;
		int unsigned r;
		lookup_codes = '{FN_GET_VALUE, FN_GET_STAMP, FN_TOUCH, FN_IDLE};
		for (int k = 0; k < pool_size; k++)
			pool[k] = {$urandom, $urandom};
		// near neighbors that differ in a single bit
		pool[1] = pool[0] ^ (64'd1 << $urandom_range(0, 63));
		pool[2] = pool[0] ^ (64'd1 << $urandom_range(0, 63));
		repeat (n_items) begin
			r = $urandom_range(0, 99);
			if (r < put_weight)
				f = FN_PUT;
			else if (r < put_weight + remove_weight)
				f = FN_REMOVE;
			else if (r >= 96)
				f = r[0] ? FN_SPARE_A : FN_SPARE_B;
			else
				f = lookup_codes[$urandom_range(0, 3)];
			if ($urandom_range(0, 99) < 92)
				key = pool[$urandom_range(0, pool_size - 1)];
			else
				key = {$urandom, $urandom};
			if ($urandom_range(0, 99) < 3)
				wall_clock = $urandom;
			else
				wall_clock = wall_clock + 32'($urandom_range(0, 5));
			send_request(f, key, $urandom, wall_clock);
		end
		wait_for_results();
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		test_random_mix(150, 18, 35, 20);
		no_gaps = 1'b0;
	endtask

	task automatic test_output_hold_off();
		hold_cycles = 150;
		no_gaps = 1'b1;
		test_random_mix(40, 10, 40, 10);
		no_gaps = 1'b0;
	endtask

	// receiver side: random stalls, none while no_gaps is set, or one long hold when asked
	initial begin
		int unsigned stall_left;
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (no_gaps) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				stall_left = pick_gap();
				out_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result status=%0d data=%h", $time, status,
					result_data);
				mismatch_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (status !== want.sts) begin
					$display("%0t: status mismatch expected=%0d actual=%0d", $time,
						want.sts, status);
					mismatch_count++;
				end
				if (result_data !== want.data) begin
					$display("%0t: result_data mismatch expected=%h actual=%h", $time,
						want.data, result_data);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FN_PUT;
		lookup_key = '0;
		put_value = '0;
		now_time = '0;
		known_count = 0;
		mismatch_count = 0;
		hold_cycles = 0;
		no_gaps = 1'b0;
		wall_clock = $urandom;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_ops();
		test_full_table();
		test_random_mix(350, 6, 35, 15);
		test_random_mix(450, 24, 50, 10);
		test_back_to_back();
		test_output_hold_off();
		test_random_mix(450, 20, 25, 30);
		test_random_mix(350, 40, 40, 20);
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
src/kat_pkg.sv
src/kat_cell.sv
src/keyed_activity_table.sv
test/tb_keyed_activity_table.sv
